@@ rtl/tgst_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the toroidal grid slot table
// no dependencies; imported by every module of the block
package tgst_pkg;

    localparam int ID_W   = 8;
    localparam int SIDE_W = 5;  // width of the grid side register
    localparam int DIV_W  = 9;  // dividend width of the shared divider
    localparam int DATA_W = 5;  // config write data, widest register

    localparam logic [ID_W-1:0] EMPTY_ID = 8'hFF;

    localparam logic REG_GRID_SIDE    = 1'b0;
    localparam logic REG_SLOTS_IN_USE = 1'b1;

    typedef enum logic [2:0] {
        OP_READ_SLOT  = 3'd0,
        OP_READ_BOX   = 3'd1,
        OP_INSERT     = 3'd2,
        OP_REMOVE     = 3'd3,
        OP_CLEAR_BOX  = 3'd4,
        OP_CLEAR_ALL  = 3'd5,
        OP_ADD_OFFSET = 3'd6,
        OP_SET_OFFSET = 3'd7
    } op_t;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [SIDE_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIV_W-1:0]  quot;
        logic [SIDE_W-1:0] rem;
    } div_rsp_t;

endpackage

@@ rtl/tgst_div.sv @@
`timescale 1ns / 1ps
// shared restoring divider, one quotient bit per cycle
// depends on tgst_pkg for the request and response structs
module tgst_div import tgst_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0]  quo_reg, quo_next;
    logic [SIDE_W-1:0] rem_reg, rem_next;
    logic [SIDE_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [SIDE_W:0]   shifted;
    logic [SIDE_W:0]   trial;
    logic              fits;

    assign shifted = {rem_reg, quo_reg[DIV_W-1]};
    assign trial   = shifted - {1'b0, dvs_reg};
    assign fits    = shifted >= {1'b0, dvs_reg};

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (req.start) begin
            quo_next = req.dividend;
            rem_next = '0;
            dvs_next = req.divisor;
            cnt_next = CNT_W'(DIV_W);
        end else if (cnt_reg != '0) begin
            rem_next  = fits ? trial[SIDE_W-1:0] : shifted[SIDE_W-1:0];
            quo_next  = {quo_reg[DIV_W-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;
    assign rsp.rem  = rem_reg;

endmodule

@@ rtl/tgst_store.sv @@
`timescale 1ns / 1ps
// box memory: one row per box, one write and one registered read port
// depends on tgst_pkg only through the shared import convention
module tgst_store import tgst_pkg::*; #(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8,
    parameter int ROW_W  = 32
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [ROW_W-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [ROW_W-1:0]  rd_data
);

    logic [ROW_W-1:0] mem [DEPTH];
    logic [ROW_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/tgst_boxop.sv @@
`timescale 1ns / 1ps
// rewrites one box row: insert with shift, or remove an id with renumbering
// depends on tgst_pkg for the id width and the empty marker
module tgst_boxop import tgst_pkg::*; #(
    parameter int SLOTS_PER_BOX = 4,
    parameter int USED_W        = 3
) (
    input  logic [SLOTS_PER_BOX*ID_W-1:0] row_in,
    input  logic                          is_remove,
    input  logic [ID_W-1:0]               id,
    input  logic [1:0]                    slot,
    input  logic [USED_W-1:0]             used,
    output logic [SLOTS_PER_BOX*ID_W-1:0] row_out
);

    logic [ID_W-1:0] box [SLOTS_PER_BOX];
    logic [ID_W-1:0] ins [SLOTS_PER_BOX];

    // remove: compact on each match, then renumber and empty the last live slot
    always_comb begin
        for (int i = 0; i < SLOTS_PER_BOX; i++) begin
            box[i] = row_in[i*ID_W +: ID_W];
        end
        for (int j = 0; j < SLOTS_PER_BOX; j++) begin
            if (j < int'(used) && box[j] == id) begin
                for (int w = 0; w < SLOTS_PER_BOX - 1; w++) begin
                    if (w >= j && w + 1 < int'(used)) begin
                        box[w] = box[w+1];
                    end
                end
                for (int k = 0; k < SLOTS_PER_BOX; k++) begin
                    if (k == int'(used) - 1) begin
                        box[k] = EMPTY_ID;
                    end
                end
            end
        end
        for (int j = 0; j < SLOTS_PER_BOX; j++) begin
            if (j + 1 < int'(used) && box[j] != EMPTY_ID && box[j] > id) begin
                box[j] = box[j] - 1'b1;
            end
            if (j == int'(used) - 1) begin
                box[j] = EMPTY_ID;
            end
        end
    end

    always_comb begin
        for (int i = 0; i < SLOTS_PER_BOX; i++) begin
            if (i < int'(slot)) begin
                ins[i] = row_in[i*ID_W +: ID_W];
            end else if (i == int'(slot)) begin
                ins[i] = id;
            end else if (i < int'(used)) begin
                ins[i] = row_in[(i-1)*ID_W +: ID_W];
            end else begin
                ins[i] = row_in[i*ID_W +: ID_W];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < SLOTS_PER_BOX; i++) begin
            row_out[i*ID_W +: ID_W] = is_remove ? box[i] : ins[i];
        end
    end

endmodule

@@ rtl/toroidal_grid_slot_table.sv @@
`timescale 1ns / 1ps
// toroidal grid slot table top level: sequencer, config and offset registers
// depends on tgst_pkg, tgst_div, tgst_store and tgst_boxop

// One item at a time: s_tready is high only while the block is idle, and each
// item returns exactly one result beat (zero payload except for the reads).
// Box addressing runs three divisions through one shared 9-step divider, and
// add and set offset run two. Remove-id walks the side*side boxes in use
// through the memory read port, one box per cycle. Clear-all rewrites all
// MAX_SIDE*MAX_SIDE rows, one per cycle, and the same clearing pass runs after
// reset, when no beat is taken; config writes are taken at any time.
module toroidal_grid_slot_table import tgst_pkg::*; #(
    parameter int MAX_SIDE      = 16,
    parameter int SLOTS_PER_BOX = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    // config write port
    input  logic              cfg_wr_en,
    input  logic              cfg_index,
    input  logic [DATA_W-1:0] cfg_data,
    // input beats
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [31:0]       s_tdata,  // op, box_index, slot, cluster_id, offset_dx, offset_dy
    // result beats
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [39:0]       m_tdata   // slot_value, all_slots
);

    localparam int DEPTH  = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ROW_W  = SLOTS_PER_BOX * ID_W;
    localparam int USED_W = $clog2(SLOTS_PER_BOX + 1);
    localparam int OFF_W  = $clog2(MAX_SIDE);
    localparam int VAL_W  = 8;

    localparam logic [1:0] PH_FIRST  = 2'd0;
    localparam logic [1:0] PH_SECOND = 2'd1;
    localparam logic [1:0] PH_THIRD  = 2'd2;

    typedef enum logic [8:0] {
        S_FILL   = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_DSTART = 9'b000000100,
        S_DWAIT  = 9'b000001000,
        S_ADDR   = 9'b000010000,
        S_ACCESS = 9'b000100000,
        S_MODIFY = 9'b001000000,
        S_SWEEP  = 9'b010000000,
        S_OUT    = 9'b100000000
    } state_t;

    state_t             state_reg, state_next;
    logic [SIDE_W-1:0]  grid_side_reg, grid_side_next;
    logic [2:0]         slots_in_use_reg, slots_in_use_next;
    logic [OFF_W-1:0]   col_off_reg, col_off_next;
    logic [OFF_W-1:0]   row_off_reg, row_off_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               reply_reg, reply_next;
    logic               pend_reg, pend_next;
    logic [ADDR_W-1:0]  pend_addr_reg, pend_addr_next;
    logic [1:0]         phase_reg, phase_next;

    op_t                op_reg, op_next;
    logic [7:0]         box_reg, box_next;
    logic [1:0]         slot_reg, slot_next;
    logic [ID_W-1:0]    id_reg, id_next;
    logic signed [4:0]  dx_reg, dx_next;
    logic signed [4:0]  dy_reg, dy_next;
    logic [DIV_W-1:0]   row_reg, row_next;
    logic [SIDE_W-1:0]  col_reg, col_next;
    logic [SIDE_W-1:0]  prow_reg, prow_next;
    logic [SIDE_W-1:0]  pcol_reg, pcol_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic [CNT_W-1:0]   boxes_reg, boxes_next;
    logic [ID_W-1:0]    slot_value_reg, slot_value_next;
    logic [31:0]        all_slots_reg, all_slots_next;

    logic [SIDE_W-1:0]  side;
    logic [USED_W-1:0]  used;
    logic               offset_op;
    logic signed [VAL_W-1:0] vx, vy, vsel, vmag;
    logic               vneg;
    logic [SIDE_W-1:0]  rem_fix;
    logic [ROW_W+31:0]  padded;
    logic               insert_live;

    div_req_t           div_req;
    div_rsp_t           div_rsp;

    logic               wr_en, rd_en;
    logic [ADDR_W-1:0]  wr_addr, rd_addr;
    logic [ROW_W-1:0]   wr_data, rd_data, box_new;

    // effective side and live slot count
    always_comb begin
        if (grid_side_reg == '0) begin
            side = SIDE_W'(1);
        end else if (int'(grid_side_reg) > MAX_SIDE) begin
            side = SIDE_W'(MAX_SIDE);
        end else begin
            side = grid_side_reg;
        end
        if (slots_in_use_reg == '0) begin
            used = USED_W'(1);
        end else if (int'(slots_in_use_reg) > SLOTS_PER_BOX) begin
            used = USED_W'(SLOTS_PER_BOX);
        end else begin
            used = USED_W'(slots_in_use_reg);
        end
    end

    assign offset_op = (op_reg == OP_ADD_OFFSET) || (op_reg == OP_SET_OFFSET);

    // signed offset values, reduced by magnitude then folded back when negative
    always_comb begin
        if (op_reg == OP_SET_OFFSET) begin
            vx = VAL_W'(dx_reg);
            vy = VAL_W'(dy_reg);
        end else begin
            vx = $signed(VAL_W'(col_off_reg)) + VAL_W'(dx_reg);
            vy = $signed(VAL_W'(row_off_reg)) + VAL_W'(dy_reg);
        end
        vsel = (phase_reg == PH_FIRST) ? vx : vy;
        vneg = vsel[VAL_W-1];
        vmag = vneg ? -vsel : vsel;
        rem_fix = (vneg && div_rsp.rem != '0) ? side - div_rsp.rem : div_rsp.rem;
    end

    always_comb begin
        div_req.start   = (state_reg == S_DSTART);
        div_req.divisor = side;
        if (offset_op) begin
            div_req.dividend = DIV_W'($unsigned(vmag));
        end else begin
            case (phase_reg)
                PH_FIRST:  div_req.dividend = DIV_W'(box_reg);
                PH_SECOND: div_req.dividend = row_reg + DIV_W'(row_off_reg);
                default:   div_req.dividend = DIV_W'(col_reg) + DIV_W'(col_off_reg);
            endcase
        end
    end

    tgst_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    tgst_boxop #(
        .SLOTS_PER_BOX (SLOTS_PER_BOX),
        .USED_W        (USED_W)
    ) u_boxop (
        .row_in    (rd_data),
        .is_remove (op_reg == OP_REMOVE),
        .id        (id_reg),
        .slot      (slot_reg),
        .used      (used),
        .row_out   (box_new)
    );

    tgst_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .ROW_W  (ROW_W)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // slots past the box read as empty
    assign padded      = {{32{1'b1}}, rd_data};
    assign insert_live = int'(slot_reg) < int'(used);

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = addr_reg;
        wr_data = {ROW_W{1'b1}};
        rd_en   = 1'b0;
        rd_addr = addr_reg;
        case (state_reg)
            S_FILL: begin
                wr_en   = 1'b1;
                wr_addr = cnt_reg[ADDR_W-1:0];
            end
            S_ACCESS: begin
                wr_en = (op_reg == OP_CLEAR_BOX);
                rd_en = (op_reg != OP_CLEAR_BOX);
            end
            S_MODIFY: begin
                wr_en   = (op_reg == OP_INSERT) && insert_live;
                wr_data = box_new;
            end
            S_SWEEP: begin
                wr_en   = pend_reg;
                wr_addr = pend_addr_reg;
                wr_data = box_new;
                rd_en   = cnt_reg < boxes_reg;
                rd_addr = cnt_reg[ADDR_W-1:0];
            end
            default: ;
        endcase
    end

    always_comb begin
        state_next        = state_reg;
        grid_side_next    = grid_side_reg;
        slots_in_use_next = slots_in_use_reg;
        col_off_next      = col_off_reg;
        row_off_next      = row_off_reg;
        cnt_next          = cnt_reg;
        reply_next        = reply_reg;
        pend_next         = pend_reg;
        pend_addr_next    = pend_addr_reg;
        phase_next        = phase_reg;
        op_next           = op_reg;
        box_next          = box_reg;
        slot_next         = slot_reg;
        id_next           = id_reg;
        dx_next           = dx_reg;
        dy_next           = dy_reg;
        row_next          = row_reg;
        col_next          = col_reg;
        prow_next         = prow_reg;
        pcol_next         = pcol_reg;
        addr_next         = addr_reg;
        boxes_next        = boxes_reg;
        slot_value_next   = slot_value_reg;
        all_slots_next    = all_slots_reg;

        if (cfg_wr_en) begin
            case (cfg_index)
                REG_GRID_SIDE:    grid_side_next    = cfg_data;
                REG_SLOTS_IN_USE: slots_in_use_next = cfg_data[2:0];
                default: ;
            endcase
        end

        case (state_reg)
            S_FILL: begin
                if (cnt_reg == CNT_W'(DEPTH - 1)) begin
                    state_next = reply_reg ? S_OUT : S_IDLE;
                    reply_next = 1'b0;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next         = op_t'(s_tdata[2:0]);
                    box_next        = s_tdata[10:3];
                    slot_next       = s_tdata[12:11];
                    id_next         = s_tdata[20:13];
                    dx_next         = $signed(s_tdata[25:21]);
                    dy_next         = $signed(s_tdata[30:26]);
                    slot_value_next = '0;
                    all_slots_next  = '0;
                    phase_next      = PH_FIRST;
                    cnt_next        = '0;
                    pend_next       = 1'b0;
                    boxes_next      = CNT_W'(side) * CNT_W'(side);
                    case (op_t'(s_tdata[2:0]))
                        OP_CLEAR_ALL: begin
                            state_next = S_FILL;
                            reply_next = 1'b1;
                        end
                        OP_REMOVE: state_next = S_SWEEP;
                        default:   state_next = S_DSTART;
                    endcase
                end
            end
            S_DSTART: state_next = S_DWAIT;
            S_DWAIT: begin
                if (div_rsp.done) begin
                    if (offset_op) begin
                        if (phase_reg == PH_FIRST) begin
                            col_off_next = OFF_W'(rem_fix);
                            phase_next   = PH_SECOND;
                            state_next   = S_DSTART;
                        end else begin
                            row_off_next = OFF_W'(rem_fix);
                            state_next   = S_OUT;
                        end
                    end else begin
                        case (phase_reg)
                            PH_FIRST: begin
                                row_next   = div_rsp.quot;
                                col_next   = div_rsp.rem;
                                phase_next = PH_SECOND;
                                state_next = S_DSTART;
                            end
                            PH_SECOND: begin
                                prow_next  = div_rsp.rem;
                                phase_next = PH_THIRD;
                                state_next = S_DSTART;
                            end
                            default: begin
                                pcol_next  = div_rsp.rem;
                                state_next = S_ADDR;
                            end
                        endcase
                    end
                end
            end
            S_ADDR: begin
                addr_next  = ADDR_W'(prow_reg) * ADDR_W'(side) + ADDR_W'(pcol_reg);
                state_next = S_ACCESS;
            end
            S_ACCESS: begin
                state_next = (op_reg == OP_CLEAR_BOX) ? S_OUT : S_MODIFY;
            end
            S_MODIFY: begin
                if (op_reg inside {OP_READ_SLOT, OP_READ_BOX}) begin
                    slot_value_next = padded[{slot_reg, 3'b000} +: ID_W];
                    all_slots_next  = padded[31:0];
                end
                state_next = S_OUT;
            end
            S_SWEEP: begin
                // read box n while box n-1 is written back
                if (cnt_reg < boxes_reg) begin
                    cnt_next       = cnt_reg + 1'b1;
                    pend_next      = 1'b1;
                    pend_addr_next = cnt_reg[ADDR_W-1:0];
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        state_next = S_OUT;
                    end
                end
            end
            S_OUT: begin
                if (m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_FILL;
            grid_side_reg    <= SIDE_W'(16);
            slots_in_use_reg <= 3'd4;
            col_off_reg      <= '0;
            row_off_reg      <= '0;
            cnt_reg          <= '0;
            reply_reg        <= 1'b0;
            pend_reg         <= 1'b0;
            phase_reg        <= PH_FIRST;
        end else begin
            state_reg        <= state_next;
            grid_side_reg    <= grid_side_next;
            slots_in_use_reg <= slots_in_use_next;
            col_off_reg      <= col_off_next;
            row_off_reg      <= row_off_next;
            cnt_reg          <= cnt_next;
            reply_reg        <= reply_next;
            pend_reg         <= pend_next;
            phase_reg        <= phase_next;
        end
        pend_addr_reg  <= pend_addr_next;
        op_reg         <= op_next;
        box_reg        <= box_next;
        slot_reg       <= slot_next;
        id_reg         <= id_next;
        dx_reg         <= dx_next;
        dy_reg         <= dy_next;
        row_reg        <= row_next;
        col_reg        <= col_next;
        prow_reg       <= prow_next;
        pcol_reg       <= pcol_next;
        addr_reg       <= addr_next;
        boxes_reg      <= boxes_next;
        slot_value_reg <= slot_value_next;
        all_slots_reg  <= all_slots_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = {all_slots_reg, slot_value_reg};

`ifndef ASSERT_OFF
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !m_tvalid)
        else $error("input taken while a result beat is pending");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("ready stayed high after an accepted beat");

    a_no_idle_write: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> state_reg != S_IDLE)
        else $error("memory written while idle");

    a_div_done_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> state_reg == S_DWAIT)
        else $error("divider finished outside the wait state");
`endif

endmodule

@@ sim/toroidal_grid_slot_table_tb.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the toroidal grid slot table
// depends on tgst_pkg and toroidal_grid_slot_table; keeps its own model of the table

module toroidal_grid_slot_table_tb;
    import tgst_pkg::*;

    localparam int GRID_MAX    = 16;
    localparam int BOX_SLOTS   = 4;
    localparam int LONG_HOLD   = 200;
    localparam int STUCK_LIMIT = 3000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 106;
    localparam logic [39:0] ALL_EMPTY = 40'hFF_FFFF_FFFF;
    localparam logic [39:0] NO_DATA   = 40'h0;

    // command beat, first field in the low bits
    typedef struct packed {
        logic              pad;
        logic signed [4:0] offset_dy;
        logic signed [4:0] offset_dx;
        logic [7:0]        cluster_id;
        logic [1:0]        slot;
        logic [7:0]        box_index;
        op_t               op;
    } grid_cmd_t;

    typedef struct packed {
        logic [31:0] all_slots;
        logic [7:0]  slot_value;
    } reply_t;

    typedef struct {
        grid_cmd_t cmd;
        bit        typed;
        reply_t    want;
    } dir_row_t;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic              cfg_index = 1'b0;
    logic [DATA_W-1:0] cfg_data  = '0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [31:0]       s_tdata   = '0;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [39:0]       m_tdata;

    // model state
    logic [7:0] slot_mem [GRID_MAX*GRID_MAX*BOX_SLOTS];
    int         col_off, row_off;
    logic [4:0] side_reg;
    logic [2:0] used_reg;

    reply_t table_replies [$];
    int     err_count;
    int     stuck_cycles;
    bit     hold_req;
    bit     quiet;

    toroidal_grid_slot_table #(
        .MAX_SIDE      (GRID_MAX),
        .SLOTS_PER_BOX (BOX_SLOTS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int eff_side();
        if (side_reg == 0) return 1;
        if (side_reg > GRID_MAX) return GRID_MAX;
        return int'(side_reg);
    endfunction

    function automatic int torus_wrap(int v, int s);
        int r;
        r = v % s;
        if (r < 0) r += s;
        return r;
    endfunction

    // updates the model table and returns the reply the block should give
    function automatic reply_t apply_grid_op(grid_cmd_t c);
        reply_t r;
        int side, used, base, rw, cl, sl, dx, dy, b, j, w, id;
        r    = '0;
        side = eff_side();
        used = (used_reg == 0) ? 1 : (used_reg > BOX_SLOTS) ? BOX_SLOTS : int'(used_reg);
        rw   = (int'(c.box_index) / side + row_off) % side;
        cl   = (int'(c.box_index) % side + col_off) % side;
        base = (rw * side + cl) * BOX_SLOTS;
        sl   = int'(c.slot);
        dx   = c.offset_dx;
        dy   = c.offset_dy;
        id   = int'(c.cluster_id);
        case (c.op)
            OP_READ_SLOT, OP_READ_BOX: begin
                r.slot_value = (sl < BOX_SLOTS) ? slot_mem[base + sl] : EMPTY_ID;
                for (j = 0; j < 4; j++)
                    r.all_slots[8*j +: 8] = (j < BOX_SLOTS) ? slot_mem[base + j] : EMPTY_ID;
            end
            OP_INSERT: begin
                if (sl < used) begin
                    for (j = used - 1; j > sl; j--) slot_mem[base + j] = slot_mem[base + j - 1];
                    slot_mem[base + sl] = c.cluster_id;
                end
            end
            OP_REMOVE: begin
                // matching pass: a duplicate shifted into the hit position is skipped
                for (b = 0; b < side * side; b++)
                    for (j = 0; j < used; j++)
                        if (int'(slot_mem[b*BOX_SLOTS + j]) == id) begin
                            for (w = j; w + 1 < used; w++)
                                slot_mem[b*BOX_SLOTS + w] = slot_mem[b*BOX_SLOTS + w + 1];
                            slot_mem[b*BOX_SLOTS + used - 1] = EMPTY_ID;
                        end
                // renumber pass, last live slot always emptied
                for (b = 0; b < side * side; b++) begin
                    for (j = 0; j + 1 < used; j++)
                        if (slot_mem[b*BOX_SLOTS + j] != EMPTY_ID
                                && int'(slot_mem[b*BOX_SLOTS + j]) > id)
                            slot_mem[b*BOX_SLOTS + j] = slot_mem[b*BOX_SLOTS + j] - 8'd1;
                    slot_mem[b*BOX_SLOTS + used - 1] = EMPTY_ID;
                end
            end
            OP_CLEAR_BOX: begin
                for (j = 0; j < BOX_SLOTS; j++) slot_mem[base + j] = EMPTY_ID;
            end
            OP_CLEAR_ALL: begin
                foreach (slot_mem[k]) slot_mem[k] = EMPTY_ID;
            end
            OP_ADD_OFFSET: begin
                col_off = torus_wrap(col_off + dx, side);
                row_off = torus_wrap(row_off + dy, side);
            end
            default: begin
                col_off = torus_wrap(dx, side);
                row_off = torus_wrap(dy, side);
            end
        endcase
        return r;
    endfunction

    function automatic dir_row_t mk_row(op_t op, int box, int sl, int cid, int dx, int dy,
                                        bit typed, logic [39:0] want);
        dir_row_t r;
        r.cmd            = '0;
        r.cmd.op         = op;
        r.cmd.box_index  = box[7:0];
        r.cmd.slot       = sl[1:0];
        r.cmd.cluster_id = cid[7:0];
        r.cmd.offset_dx  = dx[4:0];
        r.cmd.offset_dy  = dy[4:0];
        r.typed          = typed;
        r.want           = want;
        return r;
    endfunction

    task automatic send_cmd(grid_cmd_t c, bit typed, reply_t want);
        reply_t r;
        s_tdata  <= c;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        r = apply_grid_op(c);
        table_replies.push_back(typed ? want : r);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (table_replies.size() != 0) @(posedge aclk);
    endtask

    // enable drops for one cycle so back-to-back calls never collide
    task automatic write_reg(logic idx, logic [DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_GRID_SIDE) side_reg = val[4:0];
        else used_reg = val[2:0];
        @(posedge aclk);
    endtask

    // result side: random stall bursts, calm stretches, one long hold-off
    int rx_stall;
    int rx_hold;
    bit rx_calm;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (rx_hold > 0) begin
            rx_hold--;
            m_tready <= 1'b0;
        end else if (hold_req) begin
            hold_req = 1'b0;
            rx_hold  = LONG_HOLD;
            m_tready <= 1'b0;
        end else if (rx_stall > 0) begin
            rx_stall--;
            m_tready <= 1'b0;
        end else begin
            if (($urandom & 63) == 0) rx_calm = $urandom_range(0, 1);
            if (!quiet && !rx_calm && $urandom_range(0, 5) == 0) begin
                rx_stall = $urandom_range(0, 5);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        reply_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (table_replies.size() == 0) begin
                $error("result beat with no command waiting: %h", m_tdata);
                err_count++;
            end else begin
                want = table_replies.pop_front();
                if (got.slot_value !== want.slot_value) begin
                    $error("slot_value: expected %h, got %h", want.slot_value, got.slot_value);
                    err_count++;
                end
                if (got.all_slots !== want.all_slots) begin
                    $error("all_slots: expected %h, got %h", want.all_slots, got.all_slots);
                    err_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stuck_cycles = 0;
        end else if (++stuck_cycles >= STUCK_LIMIT) begin
            $display("FAIL toroidal_grid_slot_table");
            $finish;
        end
    end

    initial begin
        dir_row_t   steps [$];
        grid_cmd_t  c;
        int         side, pick, n, p;
        bit         tx_calm;
        logic [4:0] side_vals [PHASES];
        logic [4:0] used_vals [PHASES];

        foreach (slot_mem[k]) slot_mem[k] = EMPTY_ID;
        col_off  = 0;
        row_off  = 0;
        side_reg = 5'd16;
        used_reg = 3'd4;
        side_vals = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd2, 5'd7, 5'd16};
        // upper bits of the slot count are dropped by the 3-bit register
        used_vals = '{5'd4, 5'd1, 5'd0, 5'h1F, 5'd3, 5'h0A, 5'h08, 5'd4};

        steps = '{
            mk_row(OP_READ_SLOT,    0, 0,   0,   0,   0, 1, ALL_EMPTY),
            mk_row(OP_READ_BOX,   255, 3,   0,   0,   0, 1, ALL_EMPTY),
            mk_row(OP_INSERT,       0, 0,   0,   0,   0, 1, NO_DATA),
            mk_row(OP_INSERT,       0, 0, 254,   0,   0, 1, NO_DATA),
            mk_row(OP_INSERT,       0, 3,   7,   0,   0, 1, NO_DATA),
            mk_row(OP_INSERT,       0, 1, 255,   0,   0, 1, NO_DATA),
            mk_row(OP_READ_BOX,     0, 1,   0,   0,   0, 0, NO_DATA),
            mk_row(OP_INSERT,     255, 2, 128,   0,   0, 1, NO_DATA),
            mk_row(OP_SET_OFFSET,   0, 0,   0, -15,  15, 1, NO_DATA),
            mk_row(OP_READ_SLOT,    0, 0,   0,   0,   0, 0, NO_DATA),
            mk_row(OP_ADD_OFFSET,   0, 0,   0,  15, -15, 1, NO_DATA),
            mk_row(OP_READ_SLOT,  255, 2,   0,   0,   0, 0, NO_DATA),
            mk_row(OP_SET_OFFSET,   0, 0,   0, -16, -16, 1, NO_DATA),
            mk_row(OP_INSERT,      17, 0,   5,   0,   0, 1, NO_DATA),
            mk_row(OP_INSERT,      17, 0,   5,   0,   0, 1, NO_DATA),
            mk_row(OP_INSERT,      17, 3,   9,   0,   0, 1, NO_DATA),
            mk_row(OP_REMOVE,       0, 0,   5,   0,   0, 1, NO_DATA),
            mk_row(OP_READ_BOX,    17, 0,   0,   0,   0, 0, NO_DATA),
            mk_row(OP_REMOVE,       0, 0,   0,   0,   0, 1, NO_DATA),
            mk_row(OP_READ_BOX,     0, 2,   0,   0,   0, 0, NO_DATA),
            mk_row(OP_CLEAR_BOX,    0, 0,   0,   0,   0, 1, NO_DATA),
            mk_row(OP_READ_BOX,     0, 0,   0,   0,   0, 1, ALL_EMPTY),
            mk_row(OP_CLEAR_ALL,    0, 0,   0,   0,   0, 1, NO_DATA),
            mk_row(OP_READ_SLOT,  255, 3,   0,   0,   0, 1, ALL_EMPTY),
            mk_row(OP_SET_OFFSET,   0, 0,   0,   0,   0, 1, NO_DATA)
        };

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (steps[i]) send_cmd(steps[i].cmd, steps[i].typed, steps[i].want);

        tx_calm = 1'b0;
        for (p = 0; p < PHASES; p++) begin
            wait_drained();
            repeat (4) @(posedge aclk);
            write_reg(REG_GRID_SIDE, side_vals[p]);
            write_reg(REG_SLOTS_IN_USE, used_vals[p]);
            if (p == 1) hold_req = 1'b1;
            if (p == PHASES - 1) quiet = 1'b1;
            side = eff_side();
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 32 == 0) tx_calm = $urandom_range(0, 1);
                if (!quiet && !tx_calm && $urandom_range(0, 3) == 0) begin
                    s_tvalid <= 1'b0;
                    repeat ($urandom_range(1, 6)) @(posedge aclk);
                end
                c = '0;
                pick = $urandom_range(0, 99);
                if (pick < 20)      c.op = OP_READ_SLOT;
                else if (pick < 40) c.op = OP_READ_BOX;
                else if (pick < 70) c.op = OP_INSERT;
                else if (pick < 78) c.op = OP_REMOVE;
                else if (pick < 84) c.op = OP_CLEAR_BOX;
                else if (pick < 86) c.op = OP_CLEAR_ALL;
                else if (pick < 93) c.op = OP_ADD_OFFSET;
                else                c.op = OP_SET_OFFSET;
                // mostly boxes inside the grid and a small id pool so removes hit
                c.box_index  = ($urandom_range(0, 4) == 0) ? 8'($urandom)
                                                           : 8'($urandom_range(0, side*side - 1));
                c.slot       = 2'($urandom);
                c.cluster_id = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 7))
                                                          : 8'($urandom);
                c.offset_dx  = 5'($urandom);
                c.offset_dy  = 5'($urandom);
                send_cmd(c, 1'b0, '0);
            end
        end

        wait_drained();
        repeat (300) @(posedge aclk);
        if (table_replies.size() != 0) err_count++;
        if (err_count == 0)
            $display("PASS toroidal_grid_slot_table");
        else
            $display("FAIL toroidal_grid_slot_table");
        $finish;
    end

endmodule
